>>> hdl/hss_pkg.sv
`timescale 1ns / 1ps
package hss_pkg;
    typedef struct packed {
        logic        action;
        logic [9:0]  row;
        logic [3:0]  var_index;
        logic signed [15:0] value;
        logic [15:0] draw_consider;
        logic [15:0] draw_adjust;
        logic [15:0] draw_direction;
        logic [15:0] draw_amount;
        logic        last;
    } t_request;

    typedef struct packed {
        logic [31:0] best_fitness;
        logic [31:0] worst_fitness;
        logic [31:0] vector_fitness;
        logic        replaced;
        logic        out_of_range;
    } t_result;

    localparam logic [2:0] REG_CONSIDER = 3'd0;
    localparam logic [2:0] REG_PITCH    = 3'd1;
    localparam logic [2:0] REG_BW       = 3'd2;
    localparam logic [2:0] REG_LOWER    = 3'd3;
    localparam logic [2:0] REG_UPPER    = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_IMPROVISE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take;        // latch request, start coordinate work
        logic coord_write; // write built coordinate
        logic fit_clear;   // clear fitness position counter and replaced flag
        logic fit_rd;      // issue coordinate read for fitness
        logic fit_acc;     // accumulate squared coordinate (read back, or candidate on improvise)
        logic fit_store;   // store fitness of loaded row
        logic repl_write;  // copy candidate coordinate into worst row
        logic repl_fit;    // store candidate fitness into worst row
        logic scan_clear;
        logic scan_rd;
        logic scan_acc;
        logic scan_done;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic is_last;
        logic fit_last;   // fitness position counter at final coordinate
        logic better;     // candidate beats worst
        logic scan_last;  // scan counter at final row
    } t_status;
endpackage

>>> hdl/hss_ram.sv
`timescale 1ns / 1ps
module hss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> hdl/hss_ctrl.sv
`timescale 1ns / 1ps
module hss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  hss_pkg::t_status i_status,
    output hss_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import hss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COORD, S_WRITE, S_FRD, S_FACC, S_FEND, S_DECIDE,
        S_REPL, S_REPL_END, S_SRD, S_SACC, S_SDONE, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_cmd   c;

    always_comb begin
        n_state = r_state;
        c = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    c.take = 1'b1;
                    n_state = S_COORD;
                end
            end
            S_COORD: n_state = S_WRITE; // memory read of source coordinate returns
            S_WRITE: begin
                c.coord_write = 1'b1;
                c.fit_clear = 1'b1;
                n_state = i_status.is_last ? S_FRD : S_IDLE;
            end
            S_FRD: begin
                c.fit_rd = 1'b1;
                n_state = S_FACC;
            end
            S_FACC: begin
                c.fit_acc = 1'b1;
                n_state = i_status.fit_last ? S_FEND : S_FRD;
            end
            S_FEND: begin
                if (i_status.is_load) begin
                    c.fit_store = 1'b1;
                    n_state = S_SRD;
                end else begin
                    n_state = S_DECIDE;
                end
                c.scan_clear = 1'b1;
            end
            S_DECIDE: begin
                c.fit_clear = 1'b1;
                n_state = i_status.better ? S_REPL : S_SRD;
            end
            S_REPL: begin
                c.repl_write = 1'b1;
                n_state = i_status.fit_last ? S_REPL_END : S_REPL;
            end
            S_REPL_END: begin
                c.repl_fit = 1'b1;
                n_state = S_SRD;
            end
            S_SRD: begin
                c.scan_rd = 1'b1;
                n_state = S_SACC;
            end
            S_SACC: begin
                c.scan_acc = 1'b1;
                n_state = i_status.scan_last ? S_SDONE : S_SRD;
            end
            S_SDONE: begin
                c.scan_done = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                c.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = c;
    assign o_busy = (r_state != S_IDLE);
endmodule

>>> hdl/hss_dp.sv
`timescale 1ns / 1ps
module hss_dp #(
    parameter int MEMORY_ROWS = 1024,
    parameter int VECTOR_LEN  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hss_pkg::t_request i_req,
    input  hss_pkg::t_cmd     i_cmd,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output hss_pkg::t_status  o_status,
    output hss_pkg::t_result  o_result,
    output logic              o_done
);
    import hss_pkg::*;

    localparam int RW = (MEMORY_ROWS > 1) ? $clog2(MEMORY_ROWS) : 1;
    localparam int VW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int CD = MEMORY_ROWS * VECTOR_LEN;
    localparam int CW = $clog2(CD);
    localparam int SW = RW + 1;

    // configuration
    logic [15:0] r_consider, r_pitch, r_lower, r_upper;
    logic [14:0] r_bw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consider <= 16'd58982;
            r_pitch    <= 16'd26214;
            r_bw       <= 15'd819;
            r_lower    <= 16'hAE14;
            r_upper    <= 16'd20972;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CONSIDER: r_consider <= i_cfg_data;
                REG_PITCH:    r_pitch    <= i_cfg_data;
                REG_BW:       r_bw       <= i_cfg_data[14:0];
                REG_LOWER:    r_lower    <= i_cfg_data;
                REG_UPPER:    r_upper    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_request r_req;
    logic [RW-1:0] r_row;
    logic r_var_ok;
    logic [VW-1:0] r_var;
    logic [30:0] r_prod;

    // row modulo by compare and subtract; passes the row through at 1024 rows and above
    logic [RW-1:0] row_mod;
    logic [9:0]    row_rem;
    always_comb begin
        row_rem = i_req.row;
        for (int k = 9; k >= 0; k--) begin
            if (32'(row_rem) >= (32'(MEMORY_ROWS) << k))
                row_rem = row_rem - 10'(32'(MEMORY_ROWS) << k);
        end
        row_mod = RW'(row_rem);
    end

    // coordinate memory and candidate store
    logic          cm_we;
    logic [CW-1:0] cm_waddr, cm_raddr;
    logic [15:0]   cm_wdata, cm_rdata;
    logic          fm_we;
    logic [RW-1:0] fm_waddr, fm_raddr;
    logic [31:0]   fm_wdata, fm_rdata;

    logic signed [15:0] r_cand [VECTOR_LEN];
    logic [MEMORY_ROWS-1:0] r_row_valid;

    logic [VW:0]   r_pos;
    logic [SW-1:0] r_scan;
    logic [RW-1:0] r_worst_row;
    logic [31:0]   r_worst_val, r_best, r_worst;
    logic [RW-1:0] r_wr;
    logic          r_found, r_flag, r_repl;
    logic [33:0]   r_fit;
    logic          r_scan_v;

    hss_ram #(.WIDTH(16), .DEPTH(CD)) u_coords (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_waddr), .i_wdata(cm_wdata),
        .i_raddr(cm_raddr), .o_rdata(cm_rdata)
    );
    hss_ram #(.WIDTH(32), .DEPTH(MEMORY_ROWS)) u_fit (
        .i_clk(i_clk), .i_we(fm_we), .i_waddr(fm_waddr), .i_wdata(fm_wdata),
        .i_raddr(fm_raddr), .o_rdata(fm_rdata)
    );

    function automatic logic [CW-1:0] caddr(input logic [RW-1:0] r, input logic [VW-1:0] v);
        caddr = CW'(32'(r) * VECTOR_LEN + 32'(v));
    endfunction

    // improvisation of one coordinate
    logic signed [16:0] base, stepv, t_up, t_dn, lo, hi, cval;
    always_comb begin
        lo = 17'(signed'(r_lower));
        hi = 17'(signed'(r_upper));
        stepv = {1'b0, r_prod[30:16] };
        if (r_consider > r_req.draw_consider) begin
            base = 17'(signed'(cm_rdata));
            t_up = base + stepv;
            t_dn = base - stepv;
            cval = base;
            if (r_pitch > r_req.draw_adjust) begin
                if (r_req.draw_direction[15]) begin
                    if (t_up <= hi) cval = t_up;
                end else if (t_dn >= lo) cval = t_dn;
            end
        end else begin
            base = 17'(signed'(r_req.value));
            t_up = base;
            t_dn = base;
            cval = base;
        end
    end

    logic [VW-1:0] pos_idx;
    assign pos_idx = r_pos[VW-1:0];
    logic signed [15:0] cand_rd;
    assign cand_rd = r_cand[pos_idx];
    logic signed [15:0] sq_in;
    logic [31:0] sq;
    assign sq_in = r_req.action ? cand_rd : signed'(cm_rdata);
    assign sq = 32'(32'(signed'(sq_in)) * 32'(signed'(sq_in)));

    always_comb begin
        cm_we = 1'b0;
        cm_waddr = caddr(r_row, r_var);
        cm_wdata = r_req.value;
        // hold the source coordinate address of the held request
        cm_raddr = caddr(r_row, r_var);
        if (i_cmd.coord_write && r_var_ok && r_req.action == ACT_LOAD) cm_we = 1'b1;
        if (i_cmd.fit_rd) cm_raddr = caddr(r_row, pos_idx);
        if (i_cmd.repl_write) begin
            cm_we = 1'b1;
            cm_waddr = caddr(r_worst_row, pos_idx);
            cm_wdata = cand_rd;
        end
        fm_we = i_cmd.fit_store || i_cmd.repl_fit;
        fm_waddr = i_cmd.repl_fit ? r_worst_row : r_row;
        fm_wdata = r_fit[33:32] != 2'b00 ? 32'hFFFFFFFF : r_fit[31:0];
        fm_raddr = RW'(r_scan);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_worst_row <= '0;
            r_worst_val <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_cmd.coord_write && r_var_ok && r_req.action == ACT_IMPROVISE) begin
                if (cval > hi || cval < lo) r_flag <= 1'b1;
            end
            if (i_cmd.fit_store) r_row_valid[r_row] <= 1'b1;
            if (i_cmd.repl_fit) r_row_valid[r_worst_row] <= 1'b1;
            if (i_cmd.scan_done && r_found) begin
                r_worst_val <= r_worst;
                r_worst_row <= r_wr;
            end
            if (i_cmd.emit) r_flag <= 1'b0;
        end
    end

    logic [31:0] fit_sat;
    assign fit_sat = r_fit[33:32] != 2'b00 ? 32'hFFFFFFFF : r_fit[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_req;
            r_row <= row_mod;
            r_var_ok <= 32'(i_req.var_index) < VECTOR_LEN;
            r_var <= VW'(i_req.var_index);
            r_prod <= 31'(i_req.draw_amount * r_bw);
        end
        if (i_cmd.coord_write && r_var_ok && r_req.action == ACT_IMPROVISE)
            r_cand[r_var] <= cval[15:0];
        if (i_cmd.fit_clear) begin
            r_pos <= '0;
            if (!i_cmd.coord_write) r_repl <= 1'b0;
        end
        if (i_cmd.coord_write) begin
            r_fit <= '0;
            r_repl <= 1'b0;
        end
        if (i_cmd.fit_acc) begin
            r_fit <= r_fit + 34'(sq);
            r_pos <= r_pos + 1'b1;
        end
        if (i_cmd.repl_write) r_pos <= r_pos + 1'b1;
        if (i_cmd.repl_fit) r_repl <= 1'b1;
        if (i_cmd.scan_clear) begin
            r_scan <= '0;
            r_found <= 1'b0;
            r_best <= '0;
            r_worst <= '0;
            r_wr <= '0;
        end
        if (i_cmd.scan_rd) r_scan_v <= r_row_valid[RW'(r_scan)];
        if (i_cmd.scan_acc) begin
            r_scan <= r_scan + 1'b1;
            if (r_scan_v) begin
                if (!r_found) begin
                    r_best <= fm_rdata;
                    r_worst <= fm_rdata;
                    r_wr <= RW'(r_scan);
                    r_found <= 1'b1;
                end else begin
                    if (fm_rdata < r_best) r_best <= fm_rdata;
                    if (fm_rdata > r_worst) begin
                        r_worst <= fm_rdata;
                        r_wr <= RW'(r_scan);
                    end
                end
            end
        end
    end

    assign o_status.is_load  = (r_req.action == ACT_LOAD);
    assign o_status.is_last  = r_req.last;
    assign o_status.fit_last = (r_pos == (VW+1)'(VECTOR_LEN - 1));
    assign o_status.better   = (fit_sat < r_worst_val);
    assign o_status.scan_last = (r_scan == SW'(MEMORY_ROWS - 1));

    assign o_result.best_fitness   = r_best;
    assign o_result.worst_fitness  = r_worst;
    assign o_result.vector_fitness = fit_sat;
    assign o_result.replaced       = r_repl;
    assign o_result.out_of_range   = r_flag;
    assign o_done = i_cmd.emit;
endmodule

>>> hdl/harmony_search_step_engine.sv
`timescale 1ns / 1ps
// Channel  | Ports                                   | Handshake
// request  | i_start, i_req                          | taken when i_start && !busy
// result   | o_done, o_result                        | one-cycle strobe, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data         | written on any edge with i_cfg_we
//
// A request without last runs a coordinate read, build and write.
// A request with last adds a fitness pass over the vector (stored for a load), a decision for a
// candidate plus a replacement of the worst row when it wins, and a
// rescan of the fitness memory.
// Reset is synchronous, active low; memories are not cleared, row valid bits are.
// The result cannot be stalled; o_done shows for exactly one cycle.
module harmony_search_step_engine #(
    parameter int MEMORY_ROWS = 1024,
    parameter int VECTOR_LEN  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              busy,
    input  hss_pkg::t_request i_req,
    output logic              o_done,
    output hss_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);
    import hss_pkg::*;

    t_cmd    cmd;
    t_status status;

    hss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    hss_dp #(.MEMORY_ROWS(MEMORY_ROWS), .VECTOR_LEN(VECTOR_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_status(status), .o_result(o_result), .o_done(o_done)
    );
endmodule
